// File: rtl/core/modular_exponentiation_defines.svh
// Assertion macros for the modular exponentiation block.
// Included by the top level; has no dependencies.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular exponentiation assertion failed");
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular exponentiation assertion failed");
`else
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/mexp_pkg.sv
// Package for the modular exponentiation block: operand width and types.
// Has no dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  parameter int OPERAND_WIDTH = 31;
  parameter int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [CNT_WIDTH-1:0]     count_t;

endpackage

// File: rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block (bit-serial square-and-multiply).
// Depends on mexp_pkg and modular_exponentiation_defines.svh.
//
// Usage: write the modulus (reset value 23) over the cfg channel only while the
// block is idle; the block itself does not enforce this. Each input transaction
// carries a base and an exponent; each output transaction returns base^exponent
// mod modulus and an error flag, set with a zero result when the modulus is zero.
// Operation: the base is first reduced modulo the modulus, one bit per cycle. Then,
// for every exponent bit up to the highest set one, a pass forms both the product
// and the square with one multiplier bit per cycle, with a check state between
// passes. A zero modulus skips both steps and goes straight to the finish state.
// One item is processed at a time. The next input transaction is accepted as soon
// as the result has moved into the output register, even if that result is still
// waiting for out_ready. A stalled receiver holds the finished result back, and
// the block waits with it until the output register frees up.
// Reset (synchronous, active low) empties the block and restores the modulus.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mexp_pkg::operand_t  cfg_modulus,
  input  logic                in_valid,
  output logic                in_ready,
  input  mexp_pkg::operand_t  in_base_value,
  input  mexp_pkg::operand_t  in_exponent_value,
  output logic                out_valid,
  input  logic                out_ready,
  output mexp_pkg::operand_t  out_power_result,
  output logic                out_modulus_error
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_MULT,
    S_FINISH
  } state_t;

  typedef logic [OPERAND_WIDTH:0] wide_t;

  function automatic operand_t add_mod(operand_t a, operand_t b, operand_t m);
    wide_t s;
    wide_t d;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      d = s - {1'b0, m};
    end else begin
      d = s;
    end
    return d[OPERAND_WIDTH-1:0];
  endfunction

  state_t   state_r, state_nxt;
  operand_t mod_r, mod_nxt;
  operand_t exp_r, exp_nxt;
  operand_t base_r, base_nxt;
  operand_t ans_r, ans_nxt;
  operand_t dbl_r, dbl_nxt;
  operand_t acc_ans_r, acc_ans_nxt;
  operand_t acc_sq_r, acc_sq_nxt;
  operand_t mlt_ans_r, mlt_ans_nxt;
  operand_t mlt_sq_r, mlt_sq_nxt;
  count_t   cnt_r, cnt_nxt;
  logic     err_r, err_nxt;
  logic     out_valid_r, out_valid_nxt;
  operand_t out_power_r, out_power_nxt;
  logic     out_err_r, out_err_nxt;

  wide_t    rem_wide;
  wide_t    rem_sub;
  operand_t acc_ans_step;
  operand_t acc_sq_step;

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_power_result  = out_power_r;
  assign out_modulus_error = out_err_r;

  assign rem_wide     = {base_r, mlt_sq_r[OPERAND_WIDTH-1]};
  assign rem_sub      = rem_wide - {1'b0, mod_r};
  assign acc_ans_step = mlt_ans_r[0] ? add_mod(acc_ans_r, dbl_r, mod_r) : acc_ans_r;
  assign acc_sq_step  = mlt_sq_r[0] ? add_mod(acc_sq_r, dbl_r, mod_r) : acc_sq_r;

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = cfg_valid ? cfg_modulus : mod_r;
    exp_nxt       = exp_r;
    base_nxt      = base_r;
    ans_nxt       = ans_r;
    dbl_nxt       = dbl_r;
    acc_ans_nxt   = acc_ans_r;
    acc_sq_nxt    = acc_sq_r;
    mlt_ans_nxt   = mlt_ans_r;
    mlt_sq_nxt    = mlt_sq_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_power_nxt = out_power_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (mod_r == '0) begin
            ans_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            err_nxt    = 1'b0;
            ans_nxt    = (mod_r == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
            base_nxt   = '0;
            mlt_sq_nxt = in_base_value;
            exp_nxt    = in_exponent_value;
            cnt_nxt    = CNT_WIDTH'(OPERAND_WIDTH - 1);
            state_nxt  = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (rem_wide >= {1'b0, mod_r}) begin
          base_nxt = rem_sub[OPERAND_WIDTH-1:0];
        end else begin
          base_nxt = rem_wide[OPERAND_WIDTH-1:0];
        end
        mlt_sq_nxt = mlt_sq_r << 1;
        if (cnt_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r - CNT_WIDTH'(1);
        end
      end
      S_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          dbl_nxt     = base_r;
          mlt_ans_nxt = ans_r;
          mlt_sq_nxt  = base_r;
          acc_ans_nxt = '0;
          acc_sq_nxt  = '0;
          cnt_nxt     = CNT_WIDTH'(OPERAND_WIDTH - 1);
          state_nxt   = S_MULT;
        end
      end
      S_MULT: begin
        acc_ans_nxt = acc_ans_step;
        acc_sq_nxt  = acc_sq_step;
        dbl_nxt     = add_mod(dbl_r, dbl_r, mod_r);
        mlt_ans_nxt = mlt_ans_r >> 1;
        mlt_sq_nxt  = mlt_sq_r >> 1;
        if (cnt_r == '0) begin
          if (exp_r[0]) begin
            ans_nxt = acc_ans_step;
          end
          base_nxt  = acc_sq_step;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_CHECK;
        end else begin
          cnt_nxt = cnt_r - CNT_WIDTH'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = ans_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= OPERAND_WIDTH'(23);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_r       <= exp_nxt;
    base_r      <= base_nxt;
    ans_r       <= ans_nxt;
    dbl_r       <= dbl_nxt;
    acc_ans_r   <= acc_ans_nxt;
    acc_sq_r    <= acc_sq_nxt;
    mlt_ans_r   <= mlt_ans_nxt;
    mlt_sq_r    <= mlt_sq_nxt;
    cnt_r       <= cnt_nxt;
    err_r       <= err_nxt;
    out_power_r <= out_power_nxt;
    out_err_r   <= out_err_nxt;
  end

  // An error result always carries a zero power.
  `MEXP_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && out_err_r, out_power_r == '0)
  `MEXP_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `MEXP_ASSERT_NEXT(a_pass_end, clk, rst_n, state_r == S_MULT && cnt_r == '0, state_r == S_CHECK)
  `MEXP_ASSERT_IMP(a_out_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FINISH)

endmodule

// File: verif/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: streams base and exponent transactions
// under several modulus settings and checks every result against a square-and-multiply model.
// Depends on mexp_pkg and the modular_exponentiation RTL.

module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int       W            = OPERAND_WIDTH;
  localparam operand_t MOD_RESET    = operand_t'(23);
  localparam operand_t OPND_MAX     = '1;
  localparam int       HOLD_AT      = 20;
  localparam int       HOLD_LEN     = 3000;
  localparam int       STEADY_FROM  = 120;
  localparam int       STEADY_TO    = 180;
  localparam int       DRAIN_CYCLES = 1100;
  localparam int       STALL_LIMIT  = 20000;
  localparam int       NUM_SETTINGS = 8;

  typedef struct {
    operand_t base;
    operand_t expo;
  } power_req_t;

  typedef struct {
    operand_t base;
    operand_t expo;
    operand_t power;
    logic     err;
  } power_exp_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  operand_t cfg_modulus = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  operand_t in_base_value = '0;
  operand_t in_exponent_value = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  operand_t out_power_result;
  logic     out_modulus_error;

  power_req_t pending_reqs[$];
  power_exp_t awaited_powers[$];
  operand_t   modulus_shadow = MOD_RESET;
  int         items_sent = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         settings_run = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;
  logic       steady;

  assign steady = (results_seen >= STEADY_FROM) && (results_seen < STEADY_TO);

  modular_exponentiation u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_modulus       (cfg_modulus),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_value     (in_base_value),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_power_result  (out_power_result),
    .out_modulus_error (out_modulus_error)
  );

  always #6 clk = ~clk;

  function automatic operand_t predict_power(operand_t base, operand_t expo, operand_t m);
    logic [2*W-1:0] prod;
    operand_t       acc;
    operand_t       sq;
    operand_t       e;
    if (m == '0) begin
      return '0;
    end
    sq  = base % m;
    acc = (m == operand_t'(1)) ? '0 : operand_t'(1);
    e   = expo;
    while (e != '0) begin
      if (e[0]) begin
        prod = {{W{1'b0}}, acc} * {{W{1'b0}}, sq};
        acc  = operand_t'(prod % {{W{1'b0}}, m});
      end
      prod = {{W{1'b0}}, sq} * {{W{1'b0}}, sq};
      sq   = operand_t'(prod % {{W{1'b0}}, m});
      e    = e >> 1;
    end
    return acc;
  endfunction

  function automatic operand_t pick_operand(bit near_modulus);
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    len = $urandom_range(1, W);
    if (sel < 8) begin
      return '0;
    end
    if (sel < 13) begin
      return operand_t'(1);
    end
    if (sel < 18) begin
      return OPND_MAX;
    end
    if (near_modulus && sel < 30) begin
      return modulus_shadow + operand_t'($urandom_range(0, 2)) - operand_t'(1);
    end
    return operand_t'($urandom) & operand_t'((64'd1 << len) - 64'd1);
  endfunction

  task automatic queue_item(operand_t base, operand_t expo);
    power_req_t req;
    req.base = base;
    req.expo = expo;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || awaited_powers.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(operand_t value);
    cfg_valid   <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    modulus_shadow = value;
  endtask

  always @(posedge clk) begin : driver
    power_req_t req;
    power_exp_t exp_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_item.base  = in_base_value;
        exp_item.expo  = in_exponent_value;
        exp_item.power = predict_power(in_base_value, in_exponent_value, modulus_shadow);
        exp_item.err   = (modulus_shadow == '0);
        awaited_powers.push_back(exp_item);
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          req = pending_reqs.pop_front();
          in_valid          <= 1'b1;
          in_base_value     <= req.base;
          in_exponent_value <= req.expo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls once for a long stretch so the block backs up into its input.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin : monitor
    power_exp_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (awaited_powers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, power %0d error %0b", $time,
                 out_power_result, out_modulus_error);
      end else begin
        want = awaited_powers.pop_front();
        if (out_power_result !== want.power) begin
          mismatches++;
          $display("%0t: power mismatch for base %0d exponent %0d: expected %0d, actual %0d",
                   $time, want.base, want.expo, want.power, out_power_result);
        end
        if (out_modulus_error !== want.err) begin
          mismatches++;
          $display("%0t: error flag mismatch for base %0d exponent %0d: expected %0b, actual %0b",
                   $time, want.base, want.expo, want.err, out_modulus_error);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    operand_t phase_mod[NUM_SETTINGS];
    int       phase_items[NUM_SETTINGS];
    phase_mod   = '{MOD_RESET, operand_t'(1), operand_t'(0), OPND_MAX, operand_t'($urandom),
                    operand_t'(2), operand_t'(1) << 30, operand_t'($urandom_range(3, 255))};
    phase_items = '{40, 16, 16, 50, 50, 16, 40, 40};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_item('0, '0);
    queue_item('0, operand_t'(5));
    queue_item(OPND_MAX, '0);
    queue_item(OPND_MAX, OPND_MAX);
    queue_item(operand_t'(1), OPND_MAX);
    queue_item(operand_t'(23), operand_t'(3));
    queue_item(operand_t'(22), operand_t'(1));
    queue_item(operand_t'(22), operand_t'(2));
    queue_item(operand_t'(24), operand_t'(7));
    queue_item(operand_t'(5), operand_t'(22));
    queue_item(operand_t'(2), operand_t'(11));
    queue_item(operand_t'(7), operand_t'(1) << 30);
    queue_item(operand_t'(31'h2AAAAAAA), operand_t'(31'h55555555));
    queue_item(operand_t'(31'h55555555), operand_t'(31'h2AAAAAAA));
    queue_item(operand_t'(3), operand_t'(1));
    queue_item(operand_t'(46), '0);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        wait_idle();
        write_modulus(phase_mod[p]);
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        queue_item(pick_operand(1'b1), pick_operand(1'b0));
      end
      settings_run++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d transactions sent and %0d results checked over %0d modulus settings",
             items_sent, results_seen, settings_run);
    $display("(zero, one, two, a power of two, the largest and random), with a %0d-cycle stall.",
             HOLD_LEN);
    if (mismatches == 0 && awaited_powers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
